// ===== hdl/dpom_pkg.sv =====
// dpom_pkg: shared types and constants of the dust pulse occupancy meter
// used by dpom_div and dust_pulse_occupancy_meter; no dependencies
`timescale 1ns / 1ps

package dpom_pkg;

    localparam int NUM_W = 46;   // widest dividend: 32-bit total times 10000
    localparam int DEN_W = 20;
    localparam int Q_W   = 16;
    localparam int LEN_W = 6;

    localparam logic [LEN_W-1:0] OCC_LEN  = 6'd46;
    localparam logic [LEN_W-1:0] PROD_LEN = 6'd25;

    localparam logic [13:0] OCC_FULL = 14'd10000;

    // concentration curve: three segment limits, and one coefficient, offset and divisor per segment
    localparam logic [13:0] CRV_LIMIT [3] = '{14'd200, 14'd400, 14'd1500};
    localparam logic [11:0] CRV_COEF  [4] = '{12'd143, 12'd208, 12'd1155, 12'd2354};
    localparam logic [14:0] CRV_OFF   [4] = '{15'd0, 15'd130, 15'd1572, 15'd19560};
    localparam logic [9:0]  CRV_DEN   [4] = '{10'd200, 10'd300, 10'd1000, 10'd1000};

    typedef struct packed {
        logic [NUM_W-1:0] num;   // dividend, left aligned
        logic [LEN_W-1:0] len;   // number of dividend bits to consume
        logic [DEN_W-1:0] den;   // divisor, never zero
    } div_req_t;

endpackage

// ===== hdl/dpom_ram.sv =====
// dpom_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dpom_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/dpom_div.sv =====
// dpom_div: bit-serial restoring divider, one quotient bit per cycle
// depends on dpom_pkg
`timescale 1ns / 1ps

module dpom_div
    import dpom_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  div_req_t       req,
    output logic           done,
    output logic [Q_W-1:0] quot,
    output logic           ovf
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [Q_W-1:0]   quot_reg, quot_next;
    logic             ovf_reg, ovf_next;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {rem_reg, num_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = rem_sh >= {1'b0, den_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;

        if (busy_reg) begin
            num_next  = {num_reg[NUM_W-2:0], 1'b0};
            rem_next  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            quot_next = {quot_reg[Q_W-2:0], ge};
            // quotient bits beyond the register only mark overflow
            ovf_next  = ovf_reg | quot_reg[Q_W-1];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == LEN_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            busy_next = 1'b1;
            cnt_next  = req.len;
            num_next  = req.num;
            den_next  = req.den;
            rem_next  = '0;
            quot_next = '0;
            ovf_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;
    assign ovf  = ovf_reg;

endmodule

// ===== hdl/dust_pulse_occupancy_meter.sv =====
// dust_pulse_occupancy_meter: two-channel low pulse occupancy dust meter, top level
// depends on dpom_pkg, dpom_div and dpom_ram
`timescale 1ns / 1ps

// Usage
// The s_ channel takes one item per event: s_tuser holds the operation (fine pin
// edge, coarse pin edge, end of sample period), s_tdata the timestamp and pin level.
// Every item yields one result item on the m_ channel with both averaged
// concentrations and, in m_tuser, a flag that the item closed a sample period.
// The cfg_ port writes the period length, the smoothing weight and the averaging
// mode; write it only while the block is idle.
// Items are handled one at a time. A pin edge goes through the S_PUT state into
// the output register, and the next item is taken only once the block is back in
// S_IDLE. A period end runs, per channel, a multiply or sum state before each pass
// of the shared bit-serial divider, which consumes 46 dividend bits for occupancy,
// 25 for the curve and 25 for the exponential average or 16+clog2(RING_DEPTH)
// for the ring mean. s_tready is high only between items.
// The result sits in an output register; while the receiver stalls the block
// finishes the next item and then holds until the register is free.
// Reset clears the totals, averages, ring valid bits and head, and restores
// the register defaults; the ring memory itself needs no clearing pass.
module dust_pulse_occupancy_meter
    import dpom_pkg::*;
#(
    parameter int RING_DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // event_time_us[31:0], pin_level[32], zero fill
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // coarse_concentration[14:0], fine_concentration[29:15]
    output logic [0:0]  m_tuser,   // sample_done[0]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SW = 16 + AW;

    localparam logic [1:0] OP_FINE  = 2'd0;
    localparam logic [1:0] OP_COARSE = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_WEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL_OCC = 4'd1;
    localparam logic [3:0] S_DIV_OCC = 4'd2;
    localparam logic [3:0] S_MUL_CRV = 4'd3;
    localparam logic [3:0] S_DIV_CRV = 4'd4;
    localparam logic [3:0] S_MUL_SM  = 4'd5;
    localparam logic [3:0] S_DIV_SM  = 4'd6;
    localparam logic [3:0] S_SUM     = 4'd7;
    localparam logic [3:0] S_DIV_MEAN = 4'd8;
    localparam logic [3:0] S_RING_WR = 4'd9;
    localparam logic [3:0] S_PUT     = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [19:0]      period_reg, period_next;
    logic [7:0]       weight_reg, weight_next;
    logic             mode_reg, mode_next;
    logic [31:0]      start_reg [2];
    logic [31:0]      start_next [2];
    logic [31:0]      total_reg [2];
    logic [31:0]      total_next [2];
    logic [15:0]      avg_reg [2];
    logic [15:0]      avg_next [2];
    logic [15:0]      mean_reg [2];
    logic [15:0]      mean_next [2];
    logic [15:0]      samp_reg [2];
    logic [15:0]      samp_next [2];
    logic [SW-1:0]    sum_reg [2];
    logic [SW-1:0]    sum_next [2];
    logic [AW-1:0]    head_reg, head_next;
    logic [RING_DEPTH-1:0] valid_reg, valid_next;
    logic             ch_reg, ch_next;
    logic             go_reg, go_next;
    logic             done_reg, done_next;
    logic [NUM_W-1:0] prod_reg, prod_next;
    logic [13:0]      lpo_reg, lpo_next;
    logic [1:0]       seg_reg, seg_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [31:0]      m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    div_req_t         div_req;
    logic             div_done;
    logic [Q_W-1:0]   div_quot;
    logic             div_ovf;
    logic             ram_we;
    logic [31:0]      ram_rdata;

    logic [31:0]      ev_time;
    logic             ev_level;
    logic [19:0]      period_eff;
    logic [7:0]       weight_eff;
    logic [13:0]      lpo_calc;
    logic [25:0]      crv_num;
    logic [24:0]      sm_num;
    logic [15:0]      ring_rd;
    logic [15:0]      out_fine;
    logic [15:0]      out_coarse;

    assign ev_time    = s_tdata[31:0];
    assign ev_level   = s_tdata[32];
    assign period_eff = (period_reg == 20'd0) ? 20'd1 : period_reg;
    assign weight_eff = (weight_reg == 8'd0) ? 8'd1 : weight_reg;
    assign s_tready   = (state_reg == S_IDLE);

    dpom_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (go_reg),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot),
        .ovf     (div_ovf)
    );

    dpom_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (head_reg),
        .wdata ({samp_reg[1], samp_reg[0]}),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        // occupancy saturates at full scale
        lpo_calc = (div_ovf || div_quot > Q_W'(OCC_FULL)) ? OCC_FULL : div_quot[13:0];
        crv_num  = (seg_reg < 2'd2) ? prod_reg[25:0] + 26'(CRV_OFF[seg_reg])
                                    : prod_reg[25:0] - 26'(CRV_OFF[seg_reg]);
        sm_num   = prod_reg[24:0] + 25'(samp_reg[ch_reg]);
        ring_rd  = !valid_reg[head_reg] ? 16'd0 :
                   (ch_reg ? ram_rdata[31:16] : ram_rdata[15:0]);

        div_req.num = prod_reg;
        div_req.len = OCC_LEN;
        div_req.den = period_eff;
        unique case (state_reg)
            S_DIV_CRV: begin
                div_req.num = {crv_num[24:0], {(NUM_W-25){1'b0}}};
                div_req.len = PROD_LEN;
                div_req.den = DEN_W'(CRV_DEN[seg_reg]);
            end
            S_DIV_SM: begin
                div_req.num = {sm_num, {(NUM_W-25){1'b0}}};
                div_req.len = PROD_LEN;
                div_req.den = DEN_W'(weight_eff);
            end
            S_DIV_MEAN: begin
                div_req.num = {sum_reg[ch_reg], {(NUM_W-SW){1'b0}}};
                div_req.len = LEN_W'(SW);
                div_req.den = DEN_W'(RING_DEPTH);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        period_next   = period_reg;
        weight_next   = weight_reg;
        mode_next     = mode_reg;
        start_next    = start_reg;
        total_next    = total_reg;
        avg_next      = avg_reg;
        mean_next     = mean_reg;
        samp_next     = samp_reg;
        sum_next      = sum_reg;
        head_next     = head_reg;
        valid_next    = valid_reg;
        ch_next       = ch_reg;
        go_next       = 1'b0;
        done_next     = done_reg;
        prod_next     = prod_reg;
        lpo_next      = lpo_reg;
        seg_next      = seg_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        ram_we        = 1'b0;
        out_fine      = mode_reg ? mean_reg[0] : avg_reg[0];
        out_coarse    = mode_reg ? mean_reg[1] : avg_reg[1];

        if (cfg_we) begin
            unique case (cfg_index)
                REG_PERIOD: period_next = cfg_data;
                REG_WEIGHT: weight_next = cfg_data[7:0];
                REG_MODE:   mode_next   = cfg_data[0];
                default: begin
                end
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    done_next  = 1'b0;
                    state_next = S_PUT;
                    priority if (s_tuser == OP_FINE || s_tuser == OP_COARSE) begin
                        if (!ev_level) begin
                            start_next[s_tuser[0]] = ev_time;
                        end else begin
                            total_next[s_tuser[0]] = total_reg[s_tuser[0]]
                                + (ev_time - start_reg[s_tuser[0]]);
                        end
                    end else if (s_tuser == OP_END) begin
                        ch_next    = 1'b0;
                        state_next = S_MUL_OCC;
                    end else begin
                        // spare code only reports the current averages
                    end
                end
            end
            S_MUL_OCC: begin
                prod_next  = NUM_W'(total_reg[ch_reg]) * NUM_W'(OCC_FULL);
                go_next    = 1'b1;
                state_next = S_DIV_OCC;
            end
            S_DIV_OCC: begin
                if (div_done) begin
                    lpo_next   = lpo_calc;
                    state_next = S_MUL_CRV;
                end
            end
            S_MUL_CRV: begin
                priority if (lpo_reg <= CRV_LIMIT[0]) begin
                    seg_next = 2'd0;
                end else if (lpo_reg <= CRV_LIMIT[1]) begin
                    seg_next = 2'd1;
                end else if (lpo_reg <= CRV_LIMIT[2]) begin
                    seg_next = 2'd2;
                end else begin
                    seg_next = 2'd3;
                end
                prod_next  = NUM_W'(lpo_reg) * NUM_W'(CRV_COEF[seg_next]);
                go_next    = 1'b1;
                state_next = S_DIV_CRV;
            end
            S_DIV_CRV: begin
                if (div_done) begin
                    samp_next[ch_reg] = div_quot;
                    state_next = mode_reg ? S_SUM : S_MUL_SM;
                end
            end
            S_MUL_SM: begin
                prod_next  = NUM_W'(weight_eff - 8'd1) * NUM_W'(avg_reg[ch_reg]);
                go_next    = 1'b1;
                state_next = S_DIV_SM;
            end
            S_DIV_SM: begin
                if (div_done) begin
                    avg_next[ch_reg] = div_quot;
                    if (!ch_reg) begin
                        ch_next    = 1'b1;
                        state_next = S_MUL_OCC;
                    end else begin
                        total_next[0] = '0;
                        total_next[1] = '0;
                        done_next     = 1'b1;
                        state_next    = S_PUT;
                    end
                end
            end
            S_SUM: begin
                // running ring sum: drop the slot being replaced, add the new sample
                sum_next[ch_reg] = sum_reg[ch_reg] - SW'(ring_rd) + SW'(samp_reg[ch_reg]);
                go_next    = 1'b1;
                state_next = S_DIV_MEAN;
            end
            S_DIV_MEAN: begin
                if (div_done) begin
                    mean_next[ch_reg] = div_quot;
                    if (!ch_reg) begin
                        ch_next    = 1'b1;
                        state_next = S_MUL_OCC;
                    end else begin
                        state_next = S_RING_WR;
                    end
                end
            end
            S_RING_WR: begin
                ram_we              = 1'b1;
                valid_next[head_reg] = 1'b1;
                head_next = (head_reg == AW'(RING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                total_next[0] = '0;
                total_next[1] = '0;
                done_next     = 1'b1;
                state_next    = S_PUT;
            end
            S_PUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, out_fine[14:0], out_coarse[14:0]};
                    m_tuser_next  = done_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            period_reg   <= 20'd100000;
            weight_reg   <= 8'd5;
            mode_reg     <= 1'b0;
            start_reg[0] <= '0;
            start_reg[1] <= '0;
            total_reg[0] <= '0;
            total_reg[1] <= '0;
            avg_reg[0]   <= '0;
            avg_reg[1]   <= '0;
            mean_reg[0]  <= '0;
            mean_reg[1]  <= '0;
            sum_reg[0]   <= '0;
            sum_reg[1]   <= '0;
            head_reg     <= '0;
            valid_reg    <= '0;
            go_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            period_reg   <= period_next;
            weight_reg   <= weight_next;
            mode_reg     <= mode_next;
            start_reg    <= start_next;
            total_reg    <= total_next;
            avg_reg      <= avg_next;
            mean_reg     <= mean_next;
            sum_reg      <= sum_next;
            head_reg     <= head_next;
            valid_reg    <= valid_next;
            go_reg       <= go_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        samp_reg    <= samp_next;
        ch_reg      <= ch_next;
        done_reg    <= done_next;
        prod_reg    <= prod_next;
        lpo_reg     <= lpo_next;
        seg_reg     <= seg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== hdl/dpom_chk.sv =====
// dpom_chk: port-level assertions for dust_pulse_occupancy_meter, bound to the top level
// depends on dust_pulse_occupancy_meter
`timescale 1ns / 1ps

module dpom_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a result waiting for the receiver stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // items are worked one at a time
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // averages never exceed the top of the concentration curve
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[14:0] <= 15'd23520) && (m_tdata[29:15] <= 15'd23520))
        else $error("concentration out of range");

endmodule

bind dust_pulse_occupancy_meter dpom_chk u_dpom_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
